// ===== rtl/buddy_page_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

`endif

// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, link marker, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGE_COUNT  = 4096;
    localparam int ORDER_COUNT = 10;
    localparam int HUGE_ORDER  = 9;

    localparam int AW       = $clog2(PAGE_COUNT);
    localparam int LW       = AW + 1;
    localparam int OW       = $clog2(ORDER_COUNT + 1);
    localparam int OIW      = $clog2(ORDER_COUNT);
    localparam int MW       = OW + 1;
    localparam int CFG_W    = 13;
    localparam int STATUS_W = 2;

    localparam logic [LW-1:0] NIL_LINK = LW'(PAGE_COUNT);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_OOM     = 2'd1,
        STATUS_DOUBLE  = 2'd2,
        STATUS_INVALID = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UNL_RD,
        S_UNL_WAIT,
        S_SPLIT,
        S_PUSH_A,
        S_PUSH_B,
        S_FREE_RD,
        S_FREE_CHK,
        S_MRG_RD,
        S_MRG_CHK,
        S_MRG_FIX,
        S_DONE
    } state_t;

endpackage

// ===== rtl/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/buddy_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator core
// Allocates single pages or huge blocks and frees blocks with buddy merging.
// ----------------------------------------------------------------------------
// After reset the block clears its order and free-flag memory, one entry per
// page, and takes no request meanwhile; configuration writes are taken at any
// time. One request is handled at a time by a sequencer around three
// single-port-read RAMs (order and flag, next link, prev link). An allocate
// scans the orders upward from the requested one, unlinks the head of the
// first non-empty list, then splits level by level and pushes each upper half.
// A free checks the page's flag and range, merges with its buddy level by level
// and pushes the final block. The result sits in an output register, so the
// next request can be taken while it waits.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [bpa_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic                         want_huge,
    input  logic [bpa_pkg::AW-1:0]       page_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bpa_pkg::AW-1:0]       block_index,
    output logic [bpa_pkg::STATUS_W-1:0] status
);

    import bpa_pkg::*;

    state_t            state_reg, state_next;
    logic              op_reg, op_next;
    logic [OW-1:0]     req_reg, req_next;
    logic [OW-1:0]     ord_reg, ord_next;
    logic [AW-1:0]     pg_reg, pg_next;
    logic [AW-1:0]     bud_reg, bud_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [LW-1:0]     head_reg [ORDER_COUNT];
    logic [LW-1:0]     head_next [ORDER_COUNT];
    logic [CFG_W-1:0]  managed_reg;
    logic [AW-1:0]     res_idx_reg, res_idx_next;
    status_t           res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [AW-1:0]     out_idx_reg, out_idx_next;
    status_t           out_st_reg, out_st_next;

    logic              meta_we;
    logic [AW-1:0]     meta_wa, meta_ra;
    logic [MW-1:0]     meta_wd, meta_rd;
    logic              next_we;
    logic [AW-1:0]     next_wa, next_ra;
    logic [LW-1:0]     next_wd, next_rd;
    logic              prev_we;
    logic [AW-1:0]     prev_wa, prev_ra;
    logic [LW-1:0]     prev_wd, prev_rd;

    logic [LW-1:0]     head_rd;
    logic              found;
    logic              scan_end;
    logic              split_more;
    logic [OW-1:0]     split_ord;
    logic [LW-1:0]     split_bud;
    logic              split_ok;
    logic [LW-1:0]     merge_bud;
    logic              merge_ok;
    logic              merge_match;
    logic              out_free;
    logic [OW-1:0]     meta_ord;
    logic              meta_flag;
    logic [AW-1:0]     low_page;

    bpa_ram #(.WIDTH(MW), .DEPTH(PAGE_COUNT)) u_meta_ram (
        .clk     (clk),
        .wr_en   (meta_we),
        .wr_addr (meta_wa),
        .wr_data (meta_wd),
        .rd_addr (meta_ra),
        .rd_data (meta_rd)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_COUNT)) u_next_ram (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_wa),
        .wr_data (next_wd),
        .rd_addr (next_ra),
        .rd_data (next_rd)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_COUNT)) u_prev_ram (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (prev_wa),
        .wr_data (prev_wd),
        .rd_addr (prev_ra),
        .rd_data (prev_rd)
    );

    assign meta_ord    = meta_rd[MW-1:1];
    assign meta_flag   = meta_rd[0];
    assign head_rd     = head_reg[ord_reg[OIW-1:0]];
    assign found       = (head_rd != NIL_LINK);
    assign scan_end    = (ord_reg >= OW'(ORDER_COUNT));
    assign split_more  = (ord_reg > req_reg);
    assign split_ord   = ord_reg - OW'(1);
    assign split_bud   = {1'b0, pg_reg} + (LW'(1) << split_ord);
    assign split_ok    = (split_ord < OW'(AW)) && (split_bud < NIL_LINK);
    assign merge_bud   = {1'b0, pg_reg} ^ (LW'(1) << ord_reg);
    assign merge_ok    = ((ord_reg + OW'(1)) < OW'(ORDER_COUNT)) && (ord_reg < OW'(AW))
                         && (merge_bud < NIL_LINK);
    assign merge_match = meta_flag && (meta_ord == ord_reg);
    assign out_free    = !out_valid_reg || out_ready;
    assign low_page    = (bud_reg < pg_reg) ? bud_reg : pg_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(PAGE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (opcode == OP_FREE) ? S_FREE_RD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
                else if (found)
                begin
                    state_next = S_UNL_RD;
                end
            end
            S_UNL_RD:   state_next = S_UNL_WAIT;
            S_UNL_WAIT: state_next = (op_reg == OP_FREE) ? S_MRG_FIX : S_SPLIT;
            S_SPLIT:
            begin
                if (!split_more)
                begin
                    state_next = S_DONE;
                end
                else if (split_ok)
                begin
                    state_next = S_PUSH_A;
                end
            end
            S_PUSH_A:   state_next = S_PUSH_B;
            S_PUSH_B:   state_next = (op_reg == OP_FREE) ? S_DONE : S_SPLIT;
            S_FREE_RD:  state_next = S_FREE_CHK;
            S_FREE_CHK:
            begin
                if (meta_flag || ({1'b0, pg_reg} >= managed_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MRG_RD;
                end
            end
            S_MRG_RD:   state_next = merge_ok ? S_MRG_CHK : S_PUSH_A;
            S_MRG_CHK:  state_next = merge_match ? S_UNL_RD : S_PUSH_A;
            S_MRG_FIX:  state_next = S_MRG_RD;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        req_next       = req_reg;
        ord_next       = ord_reg;
        pg_next        = pg_reg;
        bud_next       = bud_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        res_idx_next   = res_idx_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_st_next    = out_st_reg;
        meta_we        = 1'b0;
        meta_wa        = bud_reg;
        meta_wd        = '0;
        meta_ra        = pg_reg;
        next_we        = 1'b0;
        next_wa        = bud_reg;
        next_wd        = head_rd;
        next_ra        = bud_reg;
        prev_we        = 1'b0;
        prev_wa        = bud_reg;
        prev_wd        = NIL_LINK;
        prev_ra        = bud_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                meta_we  = 1'b1;
                meta_wa  = clr_reg;
                clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                op_next      = opcode;
                pg_next      = page_index;
                req_next     = want_huge ? OW'(HUGE_ORDER) : '0;
                ord_next     = want_huge ? OW'(HUGE_ORDER) : '0;
                res_idx_next = '0;
                res_st_next  = STATUS_OK;
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    res_st_next = STATUS_OOM;
                end
                else if (found)
                begin
                    pg_next  = head_rd[AW-1:0];
                    bud_next = head_rd[AW-1:0];
                end
                else
                begin
                    ord_next = ord_reg + OW'(1);
                end
            end
            S_UNL_RD:
            begin
                next_ra = bud_reg;
                prev_ra = bud_reg;
            end
            S_UNL_WAIT:
            begin
                if (prev_rd < NIL_LINK)
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd[AW-1:0];
                    next_wd = next_rd;
                end
                else
                begin
                    head_next[ord_reg[OIW-1:0]] = next_rd;
                end
                if (next_rd < NIL_LINK)
                begin
                    prev_we = 1'b1;
                    prev_wa = next_rd[AW-1:0];
                    prev_wd = prev_rd;
                end
            end
            S_SPLIT:
            begin
                if (split_more)
                begin
                    ord_next = split_ord;
                    if (split_ok)
                    begin
                        bud_next = split_bud[AW-1:0];
                    end
                end
                else
                begin
                    meta_we      = 1'b1;
                    meta_wa      = pg_reg;
                    meta_wd      = {req_reg, 1'b0};
                    res_idx_next = pg_reg;
                end
            end
            S_PUSH_A:
            begin
                meta_we = 1'b1;
                meta_wa = bud_reg;
                meta_wd = {ord_reg, 1'b1};
                next_we = 1'b1;
                next_wa = bud_reg;
                next_wd = head_rd;
                prev_we = 1'b1;
                prev_wa = bud_reg;
                prev_wd = NIL_LINK;
            end
            S_PUSH_B:
            begin
                if (found)
                begin
                    prev_we = 1'b1;
                    prev_wa = head_rd[AW-1:0];
                    prev_wd = {1'b0, bud_reg};
                end
                head_next[ord_reg[OIW-1:0]] = {1'b0, bud_reg};
            end
            S_FREE_RD:
            begin
                meta_ra = pg_reg;
            end
            S_FREE_CHK:
            begin
                if (meta_flag)
                begin
                    res_st_next = STATUS_DOUBLE;
                end
                else if ({1'b0, pg_reg} >= managed_reg)
                begin
                    res_st_next = STATUS_INVALID;
                end
                else
                begin
                    ord_next = meta_ord;
                end
            end
            S_MRG_RD:
            begin
                meta_ra = merge_bud[AW-1:0];
                if (merge_ok)
                begin
                    bud_next = merge_bud[AW-1:0];
                end
                else
                begin
                    bud_next = pg_reg;
                end
            end
            S_MRG_CHK:
            begin
                if (merge_match)
                begin
                    meta_we = 1'b1;
                    meta_wa = bud_reg;
                    meta_wd = {ord_reg, 1'b0};
                end
                else
                begin
                    bud_next = pg_reg;
                end
            end
            S_MRG_FIX:
            begin
                pg_next  = low_page;
                ord_next = ord_reg + OW'(1);
                meta_we  = 1'b1;
                meta_wa  = low_page;
                meta_wd  = {ord_reg + OW'(1), 1'b0};
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_st_next    = res_st_reg;
                end
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            managed_reg   <= '0;
            for (int i = 0; i < ORDER_COUNT; i++)
            begin
                head_reg[i] <= NIL_LINK;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            if (cfg_wr_en)
            begin
                managed_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        req_reg     <= req_next;
        ord_reg     <= ord_next;
        pg_reg      <= pg_next;
        bud_reg     <= bud_next;
        res_idx_reg <= res_idx_next;
        res_st_reg  <= res_st_next;
        out_idx_reg <= out_idx_next;
        out_st_reg  <= out_st_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign block_index = out_idx_reg;
    assign status      = out_st_reg;

endmodule

// ===== rtl/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator port checker
// Watches the request and result channels of the allocator core.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_core_macros.svh"

module bpa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bpa_pkg::AW-1:0]       block_index,
    input logic [bpa_pkg::STATUS_W-1:0] status
);

    import bpa_pkg::*;

    `BPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(block_index) && $stable(status))
    `BPA_ASSERT_NOW(a_fail_zero, out_valid && (status != STATUS_OK), block_index == '0)
    `BPA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .block_index (block_index),
    .status      (status)
);
